// ===== rtl/core/u8d_pkg.sv =====
// Package for the UTF-8 code point decoder: byte classes, the queued item
// record and the fixed widths and constants shared by the front, queue and back.
// Depends on nothing.
package u8d_pkg;

    localparam int unsigned CP_WIDTH    = 21;
    localparam int unsigned BYTE_WIDTH  = 8;
    localparam int unsigned COUNT_WIDTH = 3;

    localparam logic [CP_WIDTH-1:0] MAX_CP_RESET     = 21'h00FFFF;
    localparam logic [CP_WIDTH-1:0] REPLACEMENT_CP   = 21'h00FFFD;
    localparam logic [CP_WIDTH-1:0] SURROGATE_MASK   = 21'h1FF800;
    localparam logic [CP_WIDTH-1:0] SURROGATE_BASE   = 21'h00D800;

    // Lead bytes that restrict the range of the second byte.
    localparam logic [BYTE_WIDTH-1:0] LEAD_E0 = 8'hE0;
    localparam logic [BYTE_WIDTH-1:0] LEAD_ED = 8'hED;
    localparam logic [BYTE_WIDTH-1:0] LEAD_F0 = 8'hF0;
    localparam logic [BYTE_WIDTH-1:0] LEAD_F4 = 8'hF4;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } t_byte_class;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  end_of_text;
        t_byte_class           cls;
    } t_item;

endpackage

// ===== rtl/core/u8d_front.sv =====
// Front end of the UTF-8 decoder: accepts bytes and classifies each one.
// Depends on u8d_pkg.
module u8d_front
    import u8d_pkg::*;
(
    input  logic                  i_valid,
    input  logic [BYTE_WIDTH-1:0] i_data_byte,
    input  logic                  i_end_of_text,
    input  logic                  i_queue_full,
    output logic                  o_stall,
    output logic                  o_push,
    output t_item                 o_item
);

    t_byte_class cls;

    always_comb begin
        if (i_data_byte < 8'h80) begin
            cls = CLS_ASCII;
        end else if (i_data_byte < 8'hC0) begin
            cls = CLS_CONT;
        end else if (i_data_byte < 8'hC2) begin
            cls = CLS_BAD;
        end else if (i_data_byte < 8'hE0) begin
            cls = CLS_LEAD2;
        end else if (i_data_byte < 8'hF0) begin
            cls = CLS_LEAD3;
        end else if (i_data_byte <= LEAD_F4) begin
            cls = CLS_LEAD4;
        end else begin
            cls = CLS_BAD;
        end
    end

    assign o_stall = i_queue_full;
    assign o_push  = i_valid & ~i_queue_full;

    assign o_item.data_byte   = i_data_byte;
    assign o_item.end_of_text = i_end_of_text;
    assign o_item.cls         = cls;

endmodule

// ===== rtl/core/u8d_queue.sv =====
// Short first-in first-out queue of classified bytes between front and back.
// Depends on u8d_pkg.
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    output logic      o_full,
    output logic      o_not_empty,
    input  logic      i_pop,
    output t_item     o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              pop;

    assign pop    = i_pop & (r_count != '0);
    assign o_full = (r_count == FULL_CNT);

    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/u8d_back.sv =====
// Back end of the UTF-8 decoder: sequence state, value assembly, validation
// and the registered result stage. Depends on u8d_pkg.
module u8d_back
    import u8d_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CP_WIDTH-1:0]    i_max_cp,
    input  logic                   i_q_valid,
    output logic                   o_pop,
    input  t_item                  i_item,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CP_WIDTH-1:0]    o_code_point,
    output logic                   o_is_invalid,
    output logic [COUNT_WIDTH-1:0] o_bytes_consumed,
    output logic                   o_text_done
);

    logic [1:0]             r_remaining, n_remaining;
    logic [CP_WIDTH-1:0]    r_acc,       n_acc;
    logic [BYTE_WIDTH-1:0]  r_lead,      n_lead;
    logic [COUNT_WIDTH-1:0] r_seen,      n_seen;

    logic                   r_out_valid;
    logic [CP_WIDTH-1:0]    r_out_cp;
    logic                   r_out_bad;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic                   r_out_done;

    logic                   take;
    logic                   emit;
    logic                   bad;
    logic                   final_bad;
    logic [CP_WIDTH-1:0]    cp;
    logic [COUNT_WIDTH-1:0] count;
    logic                   second_ok;
    logic [1:0]             rem_dec;
    logic [COUNT_WIDTH-1:0] seen_inc;
    logic [CP_WIDTH-1:0]    payload_sh;
    logic [5:0]             payload;

    assign take  = i_q_valid & (~r_out_valid | ~i_stall);
    assign o_pop = take;

    assign payload  = i_item.data_byte[5:0];
    assign rem_dec  = r_remaining - 2'd1;
    assign seen_inc = r_seen + 3'd1;

    always_comb begin
        case (r_lead)
            LEAD_E0: second_ok = (i_item.data_byte >= 8'hA0);
            LEAD_ED: second_ok = (i_item.data_byte <= 8'h9F);
            LEAD_F0: second_ok = (i_item.data_byte >= 8'h90);
            LEAD_F4: second_ok = (i_item.data_byte <= 8'h8F);
            default: second_ok = 1'b1;
        endcase
    end

    always_comb begin
        case (rem_dec)
            2'd0:    payload_sh = {15'd0, payload};
            2'd1:    payload_sh = {9'd0, payload, 6'd0};
            2'd2:    payload_sh = {3'd0, payload, 12'd0};
            default: payload_sh = {payload[2:0], 18'd0};
        endcase
    end

    always_comb begin
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_lead      = r_lead;
        n_seen      = r_seen;
        emit        = 1'b0;
        bad         = 1'b0;
        cp          = '0;
        count       = 3'd1;
        if (r_remaining == 2'd0) begin
            case (i_item.cls)
                CLS_ASCII: begin
                    emit = 1'b1;
                    cp   = {13'd0, i_item.data_byte};
                end
                CLS_LEAD2: begin
                    n_remaining = 2'd1;
                    n_acc       = {10'd0, i_item.data_byte[4:0], 6'd0};
                end
                CLS_LEAD3: begin
                    n_remaining = 2'd2;
                    n_acc       = {5'd0, i_item.data_byte[3:0], 12'd0};
                end
                CLS_LEAD4: begin
                    n_remaining = 2'd3;
                    n_acc       = {i_item.data_byte[2:0], 18'd0};
                end
                default: begin
                    emit = 1'b1;
                    bad  = 1'b1;
                end
            endcase
            if (i_item.cls == CLS_LEAD2 || i_item.cls == CLS_LEAD3 ||
                i_item.cls == CLS_LEAD4) begin
                n_lead = i_item.data_byte;
                n_seen = 3'd1;
                if (i_item.end_of_text) begin
                    emit = 1'b1;
                    bad  = 1'b1;
                end
            end
        end else if (i_item.cls != CLS_CONT || (r_seen == 3'd1 && !second_ok)) begin
            emit  = 1'b1;
            bad   = 1'b1;
            count = seen_inc;
        end else begin
            n_remaining = rem_dec;
            n_acc       = r_acc | payload_sh;
            n_seen      = seen_inc;
            count       = seen_inc;
            if (rem_dec == 2'd0) begin
                emit = 1'b1;
                cp   = n_acc;
            end else if (i_item.end_of_text) begin
                emit = 1'b1;
                bad  = 1'b1;
            end
        end
        if (emit) begin
            n_remaining = 2'd0;
        end
    end

    assign final_bad = bad || ((cp & SURROGATE_MASK) == SURROGATE_BASE) || (cp > i_max_cp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 2'd0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_remaining <= n_remaining;
                r_seen      <= n_seen;
            end
            if (take) begin
                r_out_valid <= emit;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_acc  <= n_acc;
            r_lead <= n_lead;
        end
        if (take && emit) begin
            r_out_cp    <= final_bad ? REPLACEMENT_CP : cp;
            r_out_bad   <= final_bad;
            r_out_count <= count;
            r_out_done  <= i_item.end_of_text;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_code_point     = r_out_cp;
    assign o_is_invalid     = r_out_bad;
    assign o_bytes_consumed = r_out_count;
    assign o_text_done      = r_out_done;

endmodule

// ===== rtl/core/utf8_codepoint_decoder.sv =====
// Top level of the UTF-8 code point decoder: limit register, front end,
// byte queue and back end. Depends on u8d_pkg, u8d_front, u8d_queue, u8d_back.
//
// Usage
//   Input channel: i_valid, i_data_byte, i_end_of_text, with o_stall driven
//   back. A byte transaction completes at a rising edge with i_valid high and
//   o_stall low. Set i_end_of_text on the last byte of a text.
//   Output channel: o_valid with o_code_point, o_is_invalid, o_bytes_consumed
//   and o_text_done; the receiver drives i_stall. A result transaction
//   completes at a rising edge with o_valid high and i_stall low.
//   Configuration channel: i_cfg_valid, i_cfg_data, o_cfg_ready (always high).
//   It writes the largest accepted code point; write it only while idle.
// Timing
//   One byte is taken every cycle while o_stall is low. A byte that completes or
//   breaks a sequence shows its result after passing through the queue and
//   then the back end's result register. The back end's sequence state
//   is a loop on itself, which sets the rate at one byte per cycle.
// Reset and stalls
//   Reset empties the queue, closes any open sequence, clears the result
//   valid flag and sets the limit to U+FFFF. While the receiver stalls, the
//   result holds; bytes collect in the queue, and o_stall rises once the
//   queue holds QUEUE_DEPTH bytes.
module utf8_codepoint_decoder
    import u8d_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [BYTE_WIDTH-1:0]  i_data_byte,
    input  logic                   i_end_of_text,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CP_WIDTH-1:0]    o_code_point,
    output logic                   o_is_invalid,
    output logic [COUNT_WIDTH-1:0] o_bytes_consumed,
    output logic                   o_text_done,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CP_WIDTH-1:0]    i_cfg_data
);

    logic [CP_WIDTH-1:0] r_max_cp;
    logic                push;
    logic                queue_full;
    t_item               front_item;
    t_item               queue_item;
    logic                q_valid;
    logic                q_pop;

    // The limit register accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cp <= MAX_CP_RESET;
        end else if (i_cfg_valid) begin
            r_max_cp <= i_cfg_data;
        end
    end

    u8d_front u_front (
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .i_queue_full  (queue_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_item        (front_item)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .o_full      (queue_full),
        .o_not_empty (q_valid),
        .i_pop       (q_pop),
        .o_item      (queue_item)
    );

    u8d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_max_cp         (r_max_cp),
        .i_q_valid        (q_valid),
        .o_pop            (q_pop),
        .i_item           (queue_item),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_point     (o_code_point),
        .o_is_invalid     (o_is_invalid),
        .o_bytes_consumed (o_bytes_consumed),
        .o_text_done      (o_text_done)
    );

endmodule
